### design/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam logic [15:0] HOLDOFF_RST = 16'd2000;

  localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
  localparam logic [15:0] HW_TYPE_ETH  = 16'h0001;
  localparam logic [15:0] ARP_OP_REQ   = 16'h0001;
  localparam logic [15:0] ARP_OP_RESP  = 16'h0002;

  localparam logic [1:0]  TX_OP_NONE  = 2'd0;
  localparam logic [1:0]  TX_OP_REQ   = 2'd1;
  localparam logic [1:0]  TX_OP_REPLY = 2'd2;

  localparam logic        CMD_RESOLVE = 1'b0;
  localparam logic        CMD_FRAME   = 1'b1;

  localparam logic [47:0] MAC_BCAST = {6{8'hFF}};

  // configuration register indexes
  localparam logic        REG_LOCAL_IP = 1'b0;
  localparam logic        REG_HOLDOFF  = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_QUERY_SENT = 3'd1,
    ST_HELD_OFF   = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_IGNORED    = 3'd4,
    ST_UPDATED    = 3'd5,
    ST_REPLY_SENT = 3'd6
  } status_e;

  // item as it walks down the cell row
  typedef struct packed {
    logic        valid;
    logic        cmd;
    logic        lookup;   // item searches the table
    logic        done;     // outcome already settled
    logic        ins;      // a cell took the address as a new entry
    logic [31:0] now;
    logic [31:0] ip;
    logic [47:0] mac;
    status_e     status;
    logic [47:0] res_mac;
  } pkt_t;

endpackage

### design/arpc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_req_if
// Input channel: resolve requests and received ARP frames.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] now_ms;
  logic [31:0] query_ip;
  logic [15:0] eth_type;
  logic [15:0] hw_type;
  logic [15:0] opcode;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [47:0] target_mac;
  logic [31:0] target_ip;

  modport source (
    output valid, cmd, now_ms, query_ip, eth_type, hw_type, opcode,
           sender_mac, sender_ip, target_mac, target_ip,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_ms, query_ip, eth_type, hw_type, opcode,
           sender_mac, sender_ip, target_mac, target_ip,
    output ready
  );
endinterface

### design/arpc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_rsp_if
// Result channel: lookup status and ARP frame to transmit.
// ----------------------------------------------------------------------------
interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] resolved_mac;
  logic        tx_valid;
  logic [1:0]  tx_op;
  logic [47:0] tx_dest_mac;
  logic [47:0] tx_target_mac;
  logic [31:0] tx_target_ip;

  modport source (
    output valid, status, resolved_mac, tx_valid, tx_op, tx_dest_mac,
           tx_target_mac, tx_target_ip,
    input  ready
  );
  modport sink (
    input  valid, status, resolved_mac, tx_valid, tx_op, tx_dest_mac,
           tx_target_mac, tx_target_ip,
    output ready
  );
endinterface

### design/arpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_cell
// One cache entry: compares the passing item, updates itself, hands it on.
// ----------------------------------------------------------------------------
module arpc_cell #(
  parameter int unsigned K     = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  entry_count_i,
  input  logic [15:0]       holdoff_i,
  input  arpc_pkg::pkt_t    pkt_i,
  output arpc_pkg::pkt_t    pkt_o
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(K);

  logic [31:0] addr_q, addr_d;
  logic [47:0] hw_q, hw_d;
  logic        resolved_q, resolved_d;
  logic [31:0] last_q, last_d;

  arpc_pkg::pkt_t pkt_q, pkt_d;

  logic        search;
  logic        hit;
  logic        do_ins;
  logic [31:0] last_eff;
  logic [31:0] age;
  logic        due;

  always_comb begin
    search   = pkt_i.valid && pkt_i.lookup && !pkt_i.done;
    hit      = search && (IDX < entry_count_i) && (addr_q == pkt_i.ip);
    // first free slot takes a resolve that missed every entry before it
    do_ins   = search && (IDX == entry_count_i) && (pkt_i.cmd == arpc_pkg::CMD_RESOLVE);
    last_eff = do_ins ? 32'd0 : last_q;
    age      = pkt_i.now - last_eff;
    due      = age > {16'd0, holdoff_i};

    addr_d     = addr_q;
    hw_d       = hw_q;
    resolved_d = resolved_q;
    last_d     = last_q;
    pkt_d      = pkt_i;

    if (do_ins) begin
      addr_d     = pkt_i.ip;
      hw_d       = 48'd0;
      resolved_d = 1'b0;
      last_d     = due ? pkt_i.now : 32'd0;
      pkt_d.done   = 1'b1;
      pkt_d.ins    = 1'b1;
      pkt_d.status = due ? arpc_pkg::ST_QUERY_SENT : arpc_pkg::ST_HELD_OFF;
    end else if (hit) begin
      pkt_d.done = 1'b1;
      if (pkt_i.cmd == arpc_pkg::CMD_FRAME) begin
        hw_d         = pkt_i.mac;
        resolved_d   = 1'b1;
        pkt_d.status = arpc_pkg::ST_UPDATED;
      end else if (resolved_q) begin
        pkt_d.status  = arpc_pkg::ST_HIT;
        pkt_d.res_mac = hw_q;
      end else begin
        // known but unresolved: retry the query once the holdoff has run out
        if (due) begin
          last_d = pkt_i.now;
        end
        pkt_d.status = due ? arpc_pkg::ST_QUERY_SENT : arpc_pkg::ST_HELD_OFF;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    hw_q       <= hw_d;
    resolved_q <= resolved_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

### design/arp_cache_and_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_and_responder
// ARP cache with request holdoff and ARP request responder.
// ----------------------------------------------------------------------------
// path: input transfer into the head register, then through the register of
//   each entry cell along the row in turn, then into the result register
// one item at a time: the input stays closed until the item has left the
//   row into the result register, and while a held result is not taken
// reset: entry count cleared, local_ip 0, query_holdoff_ms 2000, no clearing
//   pass; entries above the count are never compared
module arp_cache_and_responder #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  arpc_req_if.sink    req_i,
  arpc_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  logic [31:0] local_ip_q;
  logic [15:0] holdoff_q;

  logic [CNT_W-1:0] entry_count_q, entry_count_d;
  logic             busy_q, busy_d;

  arpc_pkg::pkt_t chain [ENTRIES+1];
  arpc_pkg::pkt_t head_q, head_d;
  arpc_pkg::pkt_t res_q, res_d;
  arpc_pkg::pkt_t tail;
  logic           out_vld_q, out_vld_d;

  logic           accept;
  logic           pop;
  logic           is_arp;
  logic [ENTRIES:0] chain_vld;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      arpc_pkg::REG_LOCAL_IP: prdata = local_ip_q;
      arpc_pkg::REG_HOLDOFF:  prdata = {16'd0, holdoff_q};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= 32'd0;
      holdoff_q  <= arpc_pkg::HOLDOFF_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == arpc_pkg::REG_LOCAL_IP) begin
        local_ip_q <= pwdata;
      end else begin
        holdoff_q <= pwdata[15:0];
      end
    end
  end

  // input decode into the head of the row
  assign req_i.ready = !busy_q && (!out_vld_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign pop         = rsp_o.valid && rsp_o.ready;

  always_comb begin
    is_arp = (req_i.eth_type == arpc_pkg::ETH_TYPE_ARP) &&
             (req_i.hw_type == arpc_pkg::HW_TYPE_ETH);
    head_d         = '0;
    head_d.valid   = accept;
    head_d.cmd     = req_i.cmd;
    head_d.now     = req_i.now_ms;
    head_d.mac     = req_i.sender_mac;
    head_d.status  = arpc_pkg::ST_IGNORED;
    if (req_i.cmd == arpc_pkg::CMD_RESOLVE) begin
      head_d.lookup = 1'b1;
      head_d.ip     = req_i.query_ip;
    end else begin
      head_d.ip = req_i.sender_ip;
      if (is_arp && (req_i.opcode == arpc_pkg::ARP_OP_REQ) &&
          (req_i.target_ip == local_ip_q) && (req_i.target_mac == 48'd0)) begin
        head_d.done   = 1'b1;
        head_d.status = arpc_pkg::ST_REPLY_SENT;
      end else if (is_arp && (req_i.opcode == arpc_pkg::ARP_OP_RESP)) begin
        head_d.lookup = 1'b1;
      end else begin
        head_d.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    arpc_cell #(
      .K     (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .entry_count_i (entry_count_q),
      .holdoff_i     (holdoff_q),
      .pkt_i         (chain[k]),
      .pkt_o         (chain[k+1])
    );
  end

  assign tail = chain[ENTRIES];

  // end of the row: settle misses and load the result register
  always_comb begin
    res_d         = res_q;
    out_vld_d     = out_vld_q;
    entry_count_d = entry_count_q;
    busy_d        = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (pop) begin
      out_vld_d = 1'b0;
    end
    if (tail.valid) begin
      res_d     = tail;
      out_vld_d = 1'b1;
      busy_d    = 1'b0;
      if (!tail.done) begin
        res_d.status = (tail.cmd == arpc_pkg::CMD_RESOLVE) ?
                       arpc_pkg::ST_TABLE_FULL : arpc_pkg::ST_IGNORED;
      end
      if (tail.ins) begin
        entry_count_d = entry_count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q     <= 1'b0;
      entry_count_q <= '0;
      busy_q        <= 1'b0;
    end else begin
      out_vld_q     <= out_vld_d;
      entry_count_q <= entry_count_d;
      busy_q        <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    rsp_o.valid         = out_vld_q;
    rsp_o.status        = res_q.status;
    rsp_o.resolved_mac  = 48'd0;
    rsp_o.tx_valid      = 1'b0;
    rsp_o.tx_op         = arpc_pkg::TX_OP_NONE;
    rsp_o.tx_dest_mac   = 48'd0;
    rsp_o.tx_target_mac = 48'd0;
    rsp_o.tx_target_ip  = 32'd0;
    unique case (res_q.status)
      arpc_pkg::ST_HIT: begin
        rsp_o.resolved_mac = res_q.res_mac;
      end
      arpc_pkg::ST_QUERY_SENT: begin
        rsp_o.tx_valid     = 1'b1;
        rsp_o.tx_op        = arpc_pkg::TX_OP_REQ;
        rsp_o.tx_dest_mac  = arpc_pkg::MAC_BCAST;
        rsp_o.tx_target_ip = res_q.ip;
      end
      arpc_pkg::ST_REPLY_SENT: begin
        rsp_o.tx_valid      = 1'b1;
        rsp_o.tx_op         = arpc_pkg::TX_OP_REPLY;
        rsp_o.tx_dest_mac   = res_q.mac;
        rsp_o.tx_target_mac = res_q.mac;
        rsp_o.tx_target_ip  = res_q.ip;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i <= ENTRIES; i++) begin
      chain_vld[i] = chain[i].valid;
    end
  end

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one item in the cell row");

  a_tail_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> busy_q)
    else $error("item left the row while not busy");

  a_accept_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> head_q.valid)
    else $error("transfer did not reach the head of the row");

  a_tail_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> !out_vld_q || pop)
    else $error("result register overwritten");

endmodule
